// ----- rtl/scd_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and the sine quarter-wave table of the stereo chorus.
// Used by scd_ctrl, scd_datapath and the top level; depends on nothing.
package scd_pkg;

    localparam int LINE_LENGTH  = 4096;
    localparam int PTR_W        = $clog2(LINE_LENGTH);
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
    localparam int QUARTER      = SINE_ENTRIES / 4;
    localparam int QTR_W        = $clog2(QUARTER);
    localparam int CFG_W        = 12;
    localparam int DEP_W        = (PTR_W > CFG_W) ? PTR_W : CFG_W;
    localparam int OFF_W        = DEP_W + 17;
    localparam int MUL_W        = 18;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int ACC_W        = PROD_W + 1;
    localparam int TRQ_W        = ACC_W - 15;
    localparam int SAT_W        = TRQ_W + 1;
    localparam int PHASE_W      = 24;
    localparam int DATA_W       = 20;

    localparam logic [CFG_W-1:0] DELAY_RESET    = 12'd132;
    localparam logic [CFG_W-1:0] DEPTH_RESET    = 12'd4;
    localparam logic [19:0]      LFO_RESET      = 20'd380;
    localparam logic [14:0]      FEEDBACK_RESET = 15'd20972;
    localparam logic [15:0]      WIDTH_RESET    = 16'hF5EC;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        REG_DELAY    = 3'd0,
        REG_DEPTH    = 3'd1,
        REG_LFO      = 3'd2,
        REG_FEEDBACK = 3'd3,
        REG_WIDTH    = 3'd4
    } cfg_reg_t;

    typedef enum logic [9:0] {
        OP_IDLE   = 10'b00_0000_0001,
        OP_OFFSET = 10'b00_0000_0010,
        OP_ADDR   = 10'b00_0000_0100,
        OP_TAPA   = 10'b00_0000_1000,
        OP_TAPB   = 10'b00_0001_0000,
        OP_FEED   = 10'b00_0010_0000,
        OP_SUM    = 10'b00_0100_0000,
        OP_MIX1   = 10'b00_1000_0000,
        OP_MIX2   = 10'b01_0000_0000,
        OP_MIX3   = 10'b10_0000_0000
    } op_t;

    typedef struct packed {
        op_t  op;
        logic load;
        logic out_load;
    } cmd_t;

    typedef logic [14:0] sine_rom_t [0:QUARTER];

    // Quarter-wave magnitudes from the Q30 Taylor series, built at elaboration.
    function automatic sine_rom_t build_sine();
        sine_rom_t tab;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned mag;
        for (int k = 0; k <= QUARTER; k++)
        begin
            a   = (64'(4 * k) * HALF_PI_Q30) / SINE_ENTRIES;
            a2  = (a * a) >> 30;
            t   = Q30_ONE - a2 / 72;
            t   = Q30_ONE - ((a2 * t) >> 30) / 42;
            t   = Q30_ONE - ((a2 * t) >> 30) / 20;
            t   = Q30_ONE - ((a2 * t) >> 30) / 6;
            s   = (a * t) >> 30;
            mag = (s * 32767 + (Q30_ONE >> 1)) >> 30;
            if (mag > 32767)
            begin
                mag = 32767;
            end
            tab[k] = mag[14:0];
        end
        return tab;
    endfunction

    localparam sine_rom_t SINE_QTR = build_sine();

    function automatic logic signed [15:0] sine_value(logic [SINE_IDX_W-1:0] si);
        logic [1:0]       quad;
        logic [QTR_W:0]   k;
        logic [15:0]      mag;
        quad = si[SINE_IDX_W-1 -: 2];
        k    = quad[0] ? ((QTR_W+1)'(QUARTER) - {1'b0, si[QTR_W-1:0]})
                       : {1'b0, si[QTR_W-1:0]};
        mag  = {1'b0, SINE_QTR[k]};
        return quad[1] ? -$signed(mag) : $signed(mag);
    endfunction

    // Divide by 2^15, rounding toward zero.
    function automatic logic signed [TRQ_W-1:0] trunc_q15(logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] b;
        b = x + (x[ACC_W-1] ? ACC_W'(32767) : ACC_W'(0));
        return b[ACC_W-1:15];
    endfunction

    function automatic logic signed [15:0] sat16(logic signed [SAT_W-1:0] x);
        if (x > SAT_W'(32767))
        begin
            return 16'sh7FFF;
        end
        if (x < -SAT_W'(32768))
        begin
            return 16'sh8000;
        end
        return x[15:0];
    endfunction

endpackage

// ----- rtl/scd_in_if.sv -----
`timescale 1ns / 1ps
// Input channel of the stereo chorus: one stereo sample pair per request.
// Standalone; no package needed.
interface scd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

// ----- rtl/scd_out_if.sv -----
`timescale 1ns / 1ps
// Output channel of the stereo chorus: one processed pair per request.
// Standalone; no package needed.
interface scd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ----- rtl/scd_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/scd_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the stereo chorus: steps one request through the datapath.
// Depends on scd_pkg.
module scd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output scd_pkg::cmd_t cmd
);

    scd_pkg::op_t state_reg;
    scd_pkg::op_t state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         out_free;

    assign in_ready = (state_reg == scd_pkg::OP_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scd_pkg::OP_IDLE:   if (in_valid) state_next = scd_pkg::OP_OFFSET;
            scd_pkg::OP_OFFSET: state_next = scd_pkg::OP_ADDR;
            scd_pkg::OP_ADDR:   state_next = scd_pkg::OP_TAPA;
            scd_pkg::OP_TAPA:   state_next = scd_pkg::OP_TAPB;
            scd_pkg::OP_TAPB:   state_next = scd_pkg::OP_FEED;
            scd_pkg::OP_FEED:   state_next = scd_pkg::OP_SUM;
            scd_pkg::OP_SUM:    state_next = scd_pkg::OP_MIX1;
            scd_pkg::OP_MIX1:   state_next = scd_pkg::OP_MIX2;
            scd_pkg::OP_MIX2:   state_next = scd_pkg::OP_MIX3;
            scd_pkg::OP_MIX3:   if (out_free) state_next = scd_pkg::OP_IDLE;
            default:            state_next = scd_pkg::OP_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op       = state_reg;
        cmd.load     = in_ready && in_valid;
        cmd.out_load = (state_reg == scd_pkg::OP_MIX3) && out_free;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scd_pkg::OP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/scd_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the stereo chorus: settings, oscillators, delay lines, two lane
// multipliers and the cross-mix. Depends on scd_pkg and scd_ram.
module scd_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  scd_pkg::cmd_t              cmd,
    input  logic                       write_en,
    input  logic [2:0]                 reg_index,
    input  logic [scd_pkg::DATA_W-1:0] write_data,
    input  logic signed [15:0]         left_sample,
    input  logic signed [15:0]         right_sample,
    output logic signed [15:0]         left_out,
    output logic signed [15:0]         right_out
);

    localparam int PW = scd_pkg::PTR_W;
    localparam int DW = scd_pkg::DEP_W;
    localparam int MW = scd_pkg::MUL_W;

    // settings
    logic [scd_pkg::CFG_W-1:0] delay_reg;
    logic [scd_pkg::CFG_W-1:0] depth_reg;
    logic [19:0]               lfo_reg;
    logic [14:0]               feedback_reg;
    logic signed [15:0]        width_reg;

    // item state
    logic [PW-1:0]                     wp_reg;
    logic                              filled_reg;
    logic [scd_pkg::PHASE_W-1:0]       phase_reg [2];
    logic signed [15:0]                x_reg     [2];
    logic signed [scd_pkg::PROD_W-1:0] prod_reg  [2];
    logic signed [scd_pkg::ACC_W-1:0]  acc_reg   [2];
    logic [14:0]                       f_reg     [2];
    logic [PW-1:0]                     q_reg     [2];
    logic                              av_reg    [2];
    logic                              bv_reg    [2];
    logic signed [15:0]                sum_reg   [2];
    logic signed [15:0]                lo_reg;
    logic signed [15:0]                left_out_reg;
    logic signed [15:0]                right_out_reg;

    // combinational
    logic [DW+1:0]                     span;
    logic [DW-1:0]                     dly;
    logic [DW-1:0]                     dep;
    logic signed [15:0]                sine  [2];
    logic [scd_pkg::OFF_W-1:0]         off   [2];
    logic [PW-1:0]                     p     [2];
    logic [PW-1:0]                     raddr [2];
    logic [15:0]                       rdata [2];
    logic signed [15:0]                tap   [2];
    logic signed [MW-1:0]              op_a  [2];
    logic signed [MW-1:0]              op_b  [2];
    logic signed [scd_pkg::PROD_W-1:0] mprod [2];
    logic signed [15:0]                line_sum [2];
    logic signed [scd_pkg::ACC_W-1:0]  mix;
    logic signed [15:0]                mix_sat;
    logic signed [MW-1:0]              w_ext;
    logic signed [MW-1:0]              w_comp;
    logic [22:0]                       five_step;

    // Clamp delay and depth when delay plus twice the depth reaches the line length.
    always_comb
    begin
        span = (DW+2)'(delay_reg) + (DW+2)'({depth_reg, 1'b0});
        dly  = DW'(delay_reg);
        dep  = DW'(depth_reg);
        if (span >= (DW+2)'(scd_pkg::LINE_LENGTH))
        begin
            if ((DW+2)'(depth_reg) + (DW+2)'(10) > (DW+2)'(scd_pkg::LINE_LENGTH))
            begin
                dly = '0;
                dep = DW'(scd_pkg::LINE_LENGTH - 10);
            end
            else
            begin
                dly = DW'((DW+2)'(scd_pkg::LINE_LENGTH - 10) - (DW+2)'(depth_reg));
            end
        end
    end

    assign w_ext  = MW'(width_reg);
    assign w_comp = MW'(32768) - w_ext;
    assign mix    = scd_pkg::ACC_W'(prod_reg[0]) + scd_pkg::ACC_W'(prod_reg[1]);
    assign mix_sat = scd_pkg::sat16(scd_pkg::SAT_W'(scd_pkg::trunc_q15(mix)));

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            sine[c]  = scd_pkg::sine_value(
                phase_reg[c][scd_pkg::PHASE_W-1 -: scd_pkg::SINE_IDX_W]);
            off[c]   = scd_pkg::OFF_W'({dly, 15'b0}) + prod_reg[c][scd_pkg::OFF_W-1:0];
            p[c]     = wp_reg - off[c][15 +: PW];
            raddr[c] = (cmd.op == scd_pkg::OP_TAPA) ? q_reg[c] : p[c];
            tap[c]   = (((cmd.op == scd_pkg::OP_TAPA) && av_reg[c]) ||
                        ((cmd.op == scd_pkg::OP_TAPB) && bv_reg[c])) ? $signed(rdata[c]) : '0;
            line_sum[c] = scd_pkg::sat16(
                scd_pkg::SAT_W'(scd_pkg::trunc_q15(scd_pkg::ACC_W'(prod_reg[c])))
                + scd_pkg::SAT_W'(x_reg[c]));
            op_a[c] = '0;
            op_b[c] = '0;
            case (cmd.op)
                scd_pkg::OP_OFFSET:
                begin
                    op_a[c] = MW'({1'b0, dep});
                    op_b[c] = MW'(32768) + MW'(sine[c]);
                end
                scd_pkg::OP_TAPA:
                begin
                    op_a[c] = MW'(tap[c]);
                    op_b[c] = MW'(32768) - MW'({1'b0, f_reg[c]});
                end
                scd_pkg::OP_TAPB:
                begin
                    op_a[c] = MW'(tap[c]);
                    op_b[c] = MW'({1'b0, f_reg[c]});
                end
                scd_pkg::OP_FEED:
                begin
                    op_a[c] = MW'(scd_pkg::trunc_q15(acc_reg[c]));
                    op_b[c] = MW'({1'b0, feedback_reg});
                end
                scd_pkg::OP_MIX1:
                begin
                    // MIX1 forms the left output and MIX2 the right, each summed over both lanes
                    op_a[c] = (c == 0) ? MW'(sum_reg[1]) : MW'(sum_reg[0]);
                    op_b[c] = (c == 0) ? w_ext : w_comp;
                end
                scd_pkg::OP_MIX2:
                begin
                    op_a[c] = (c == 0) ? MW'(sum_reg[1]) : MW'(sum_reg[0]);
                    op_b[c] = (c == 0) ? w_comp : w_ext;
                end
                default:
                begin
                    op_a[c] = '0;
                    op_b[c] = '0;
                end
            endcase
            mprod[c] = op_a[c] * op_b[c];
        end
    end

    for (genvar g = 0; g < 2; g++)
    begin : g_line
        scd_ram #(
            .WIDTH (16),
            .DEPTH (scd_pkg::LINE_LENGTH)
        ) u_line (
            .clk   (clk),
            .we    (cmd.op == scd_pkg::OP_SUM),
            .waddr (wp_reg),
            .wdata (line_sum[g]),
            .raddr (raddr[g]),
            .rdata (rdata[g])
        );
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 2; c++)
        begin
            case (cmd.op)
                scd_pkg::OP_OFFSET: prod_reg[c] <= mprod[c];
                scd_pkg::OP_ADDR:
                begin
                    f_reg[c]  <= off[c][14:0];
                    q_reg[c]  <= p[c] + PW'(1);
                    av_reg[c] <= filled_reg || (p[c] < wp_reg);
                end
                scd_pkg::OP_TAPA:
                begin
                    prod_reg[c] <= mprod[c];
                    bv_reg[c]   <= filled_reg || (q_reg[c] < wp_reg);
                end
                scd_pkg::OP_TAPB:
                    acc_reg[c] <= scd_pkg::ACC_W'(prod_reg[c]) + scd_pkg::ACC_W'(mprod[c]);
                scd_pkg::OP_FEED:   prod_reg[c] <= mprod[c];
                scd_pkg::OP_SUM:    sum_reg[c]  <= line_sum[c];
                scd_pkg::OP_MIX1:   prod_reg[c] <= mprod[c];
                scd_pkg::OP_MIX2:   prod_reg[c] <= mprod[c];
                default:            ;
            endcase
        end
        if (cmd.op == scd_pkg::OP_MIX2)
        begin
            lo_reg <= mix_sat;
        end
        if (cmd.load)
        begin
            x_reg[0] <= left_sample;
            x_reg[1] <= right_sample;
        end
        if (cmd.out_load)
        begin
            left_out_reg  <= lo_reg;
            right_out_reg <= mix_sat;
        end
    end

    assign five_step = 23'(lfo_reg) + {1'b0, lfo_reg, 2'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= scd_pkg::DELAY_RESET;
            depth_reg    <= scd_pkg::DEPTH_RESET;
            lfo_reg      <= scd_pkg::LFO_RESET;
            feedback_reg <= scd_pkg::FEEDBACK_RESET;
            width_reg    <= scd_pkg::WIDTH_RESET;
            wp_reg       <= '0;
            filled_reg   <= 1'b0;
            phase_reg[0] <= '0;
            phase_reg[1] <= '0;
        end
        else
        begin
            if (write_en)
            begin
                unique case (scd_pkg::cfg_reg_t'(reg_index))
                    scd_pkg::REG_DELAY:    delay_reg    <= write_data[11:0];
                    scd_pkg::REG_DEPTH:    depth_reg    <= write_data[11:0];
                    scd_pkg::REG_LFO:      lfo_reg      <= write_data[19:0];
                    scd_pkg::REG_FEEDBACK: feedback_reg <= write_data[14:0];
                    scd_pkg::REG_WIDTH:    width_reg    <= write_data[15:0];
                    default:               ;
                endcase
            end
            if (cmd.out_load)
            begin
                phase_reg[0] <= phase_reg[0] + scd_pkg::PHASE_W'(lfo_reg);
                phase_reg[1] <= phase_reg[1] + scd_pkg::PHASE_W'(five_step[22:2]);
                wp_reg       <= wp_reg + PW'(1);
                if (wp_reg == '1)
                begin
                    filled_reg <= 1'b1;
                end
            end
        end
    end

    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule

// ----- rtl/stereo_chorus_delay.sv -----
`timescale 1ns / 1ps
// Stereo chorus with feedback: top level joining sequencer and datapath.
// Steps: offset, address, tap A, tap B, feed, sum (line write), MIX1, MIX2, MIX3;
// MIX3 waits while a result is pending, then loads the output register. One request
// at a time, stepped around one multiplier per channel and one read port per line.
// Reset: settings return to defaults, oscillators and write pointer clear; the
// lines need no clearing pass, unwritten entries read as zero until the pointer wraps.
module stereo_chorus_delay (
    input  logic                       clk,
    input  logic                       rst_n,
    scd_in_if.sink                     audio,
    scd_out_if.source                  mixed,
    input  logic                       write_en,
    input  logic [2:0]                 reg_index,
    input  logic [scd_pkg::DATA_W-1:0] write_data
);

    scd_pkg::cmd_t cmd;

    // Sequencer: accept one request in idle, then walk the steps.
    scd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (audio.valid),
        .in_ready  (audio.ready),
        .out_valid (mixed.valid),
        .out_ready (mixed.ready),
        .cmd       (cmd)
    );

    // Datapath: hold settings, read both lines, feed back, write, cross-mix.
    scd_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .write_en     (write_en),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .left_sample  (audio.left_sample),
        .right_sample (audio.right_sample),
        .left_out     (mixed.left_out),
        .right_out    (mixed.right_out)
    );

    // One request at a time: no accept directly after an accept.
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (audio.valid && audio.ready) |=> !audio.ready)
        else $error("request accepted while another is in flight");

    // Never overwrite a result that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!mixed.valid || mixed.ready))
        else $error("pending result overwritten");

    // The line write step always follows the feedback multiply.
    a_write_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == scd_pkg::OP_SUM) |-> $past(cmd.op == scd_pkg::OP_FEED))
        else $error("line written out of sequence");

endmodule
